FILE: sv/rwcp_pkg.sv
// rwcp_pkg: phases, role/kind/status codes, four-character codes and the
// result item type shared by the WAVE chunk parser modules.
// No dependencies.
`default_nettype none

package rwcp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_ID      = 3'd1,
    PH_SIZE    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_PAD     = 3'd4,
    PH_TAIL    = 3'd5,
    PH_REJECT  = 3'd6
  } phase_t;

  localparam logic [2:0] ROLE_HEADER  = 3'd0;
  localparam logic [2:0] ROLE_ID      = 3'd1;
  localparam logic [2:0] ROLE_SIZE    = 3'd2;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
  localparam logic [2:0] ROLE_PAD     = 3'd4;
  localparam logic [2:0] ROLE_TAIL    = 3'd5;
  localparam logic [2:0] ROLE_REJECT  = 3'd6;

  localparam logic [3:0] KIND_UNKNOWN = 4'd0;
  localparam logic [3:0] KIND_FMT     = 4'd1;
  localparam logic [3:0] KIND_DATA    = 4'd2;
  localparam logic [3:0] KIND_JUNK    = 4'd3;
  localparam logic [3:0] KIND_BEXT    = 4'd4;
  localparam logic [3:0] KIND_ACID    = 4'd5;
  localparam logic [3:0] KIND_IXML    = 4'd6;
  localparam logic [3:0] KIND_AXML    = 4'd7;
  localparam logic [3:0] KIND_OTHER   = 4'd8;

  localparam logic [1:0] STAT_PENDING = 2'd0;
  localparam logic [1:0] STAT_RIFF    = 2'd1;
  localparam logic [1:0] STAT_RF64    = 2'd2;
  localparam logic [1:0] STAT_REJECT  = 2'd3;

  // four-character codes, first byte in the low bits
  localparam logic [31:0] FCC_RIFF = 32'h4646_4952;
  localparam logic [31:0] FCC_RF64 = 32'h3436_4652;
  localparam logic [31:0] FCC_WAVE = 32'h4556_4157;
  localparam logic [31:0] FCC_FMT  = 32'h2074_6D66;
  localparam logic [31:0] FCC_DATA = 32'h6174_6164;
  localparam logic [31:0] FCC_JUNK = 32'h4B4E_554A;
  localparam logic [31:0] FCC_BEXT = 32'h7478_6562;
  localparam logic [31:0] FCC_ACID = 32'h6469_6361;
  localparam logic [31:0] FCC_IXML = 32'h4C4D_5869;
  localparam logic [31:0] FCC_AXML = 32'h6C6D_7861;

  localparam logic [31:0] HDR_LEN       = 32'd12;
  localparam logic [31:0] HDR_MAGIC_END = 32'd3;
  localparam logic [31:0] HDR_LAST      = 32'd11;
  localparam logic [31:0] FIELD_LEN     = 32'd4;
  localparam logic [31:0] MIN_CHUNK_M1  = 32'd7;

  typedef struct packed {
    logic [7:0]  byte_val;
    logic [2:0]  role;
    logic [3:0]  kind;
    logic [31:0] clen;
    logic [31:0] pidx;
    logic        last;
    logic [1:0]  fstat;
  } result_t;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] status;
  } walk_status_t;

  function automatic logic [3:0] classify(input logic [31:0] id);
    logic [3:0] k;
    case (id)
      FCC_FMT:  k = KIND_FMT;
      FCC_DATA: k = KIND_DATA;
      FCC_JUNK: k = KIND_JUNK;
      FCC_BEXT: k = KIND_BEXT;
      FCC_ACID: k = KIND_ACID;
      FCC_IXML: k = KIND_IXML;
      FCC_AXML: k = KIND_AXML;
      default:  k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: sv/rwcp_in_reg.sv
// rwcp_in_reg: input register holding one file byte ahead of the walker.
// Depends on nothing.
`default_nettype none

module rwcp_in_reg (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] file_byte,
  input  wire logic       take,
  output logic            hold_valid,
  output logic [7:0]      hold_byte
);

  assign in_ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= file_byte;
    end
  end

endmodule

`default_nettype wire

FILE: sv/rwcp_walker.sv
// rwcp_walker: header check and chunk walk state; computes one result per byte.
// Depends on rwcp_pkg.
`default_nettype none

module rwcp_walker
  import rwcp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] file_len,
  input  wire logic [7:0]  byte_in,
  input  wire logic        take,
  output result_t          res,
  output walk_status_t     wstat
);

  logic [31:0] pos, pos_next;
  phase_t      phase, phase_next;
  logic [31:0] id_sh, id_sh_next;
  logic [31:0] size_sh, size_sh_next;
  logic [31:0] blf, blf_next;
  logic [3:0]  kind_reg, kind_reg_next;
  logic [1:0]  status, status_next;
  logic        pad, pad_next;

  logic [31:0] after;
  logic        past_end;
  logic [31:0] id_shifted, size_shifted;
  logic [31:0] blf_eff, blf_dec, size_clamp;
  logic [3:0]  kind_eff;

  assign wstat = '{phase: phase, status: status};

  always_comb begin
    pos_next      = (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;
    phase_next    = phase;
    id_sh_next    = id_sh;
    size_sh_next  = size_sh;
    blf_next      = blf;
    kind_reg_next = kind_reg;
    status_next   = status;
    pad_next      = pad;

    // bytes left after this one: file_len - pos - 1
    after        = file_len + ~pos;
    past_end     = pos >= file_len;
    id_shifted   = {byte_in, id_sh[31:8]};
    size_shifted = {byte_in, size_sh[31:8]};
    blf_eff      = blf;
    blf_dec      = blf - 32'd1;
    size_clamp   = size_shifted;
    kind_eff     = kind_reg;

    res.byte_val = byte_in;
    res.role     = ROLE_HEADER;
    res.kind     = KIND_UNKNOWN;
    res.clen     = 32'd0;
    res.pidx     = 32'd0;
    res.last     = 1'b0;
    res.fstat    = STAT_PENDING;

    if (phase == PH_REJECT) begin
      res.role = ROLE_REJECT;
    end else if (phase == PH_HEADER) begin
      if (file_len < HDR_LEN) begin
        phase_next  = PH_REJECT;
        status_next = STAT_REJECT;
        res.role    = ROLE_REJECT;
      end else begin
        id_sh_next = id_shifted;
        if (pos == HDR_MAGIC_END) begin
          if (id_shifted == FCC_RIFF) begin
            status_next = STAT_RIFF;
          end else if (id_shifted == FCC_RF64) begin
            status_next = STAT_RF64;
          end else begin
            status_next = STAT_REJECT;
            phase_next  = PH_REJECT;
            res.role    = ROLE_REJECT;
          end
        end else if (pos >= HDR_LAST) begin
          if (id_shifted == FCC_WAVE && (status == STAT_RIFF || status == STAT_RF64)) begin
            phase_next = PH_ID;
            blf_next   = FIELD_LEN;
          end else begin
            status_next = STAT_REJECT;
            phase_next  = PH_REJECT;
            res.role    = ROLE_REJECT;
          end
        end
      end
    end else if (past_end || phase == PH_TAIL) begin
      res.role = ROLE_TAIL;
    end else begin
      unique case (phase)
        PH_ID: begin
          if (blf >= FIELD_LEN && after < MIN_CHUNK_M1) begin
            phase_next = PH_TAIL;
            res.role   = ROLE_TAIL;
          end else begin
            res.role = ROLE_ID;
            if (blf >= FIELD_LEN) begin
              blf_eff  = FIELD_LEN;
              kind_eff = KIND_UNKNOWN;
            end
            blf_dec    = blf_eff - 32'd1;
            id_sh_next = id_shifted;
            if (blf_dec == 32'd0) begin
              kind_eff   = classify(id_shifted);
              phase_next = PH_SIZE;
              blf_next   = FIELD_LEN;
            end else begin
              blf_next = blf_dec;
            end
            kind_reg_next = kind_eff;
            res.kind      = kind_eff;
          end
        end
        PH_SIZE: begin
          res.role = ROLE_SIZE;
          res.kind = kind_reg;
          if (blf == 32'd0) begin
            blf_dec = 32'd0;
          end
          if (blf_dec == 32'd0) begin
            if (size_shifted > after) begin
              size_clamp = after;
            end
            size_sh_next = size_clamp;
            res.clen     = size_clamp;
            pad_next     = size_clamp[0];
            if (size_clamp == 32'd0) begin
              phase_next = PH_ID;
              blf_next   = FIELD_LEN;
            end else begin
              phase_next = PH_PAYLOAD;
              blf_next   = size_clamp;
            end
          end else begin
            size_sh_next = size_shifted;
            blf_next     = blf_dec;
          end
        end
        PH_PAYLOAD: begin
          res.role = ROLE_PAYLOAD;
          res.kind = kind_reg;
          res.clen = size_sh;
          if (blf == 32'd0 || blf > size_sh) begin
            blf_eff = 32'd1;
          end
          blf_dec  = blf_eff - 32'd1;
          res.pidx = size_sh - blf_eff;
          res.last = (blf_eff == 32'd1);
          blf_next = blf_dec;
          if (blf_dec == 32'd0) begin
            if (pad) begin
              phase_next = PH_PAD;
            end else begin
              phase_next = PH_ID;
              blf_next   = FIELD_LEN;
            end
          end
        end
        PH_PAD: begin
          res.role   = ROLE_PAD;
          res.kind   = kind_reg;
          res.clen   = size_sh;
          pad_next   = 1'b0;
          phase_next = PH_ID;
          blf_next   = FIELD_LEN;
        end
        default: begin
          res.role   = ROLE_TAIL;
          phase_next = PH_TAIL;
        end
      endcase
    end

    res.fstat = (phase_next == PH_HEADER) ? STAT_PENDING : status_next;
    if (res.role == ROLE_REJECT) begin
      res.fstat = STAT_REJECT;
      res.kind  = KIND_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= 32'd0;
      phase    <= PH_HEADER;
      id_sh    <= 32'd0;
      size_sh  <= 32'd0;
      blf      <= 32'd0;
      kind_reg <= KIND_UNKNOWN;
      status   <= STAT_PENDING;
      pad      <= 1'b0;
    end else if (take) begin
      pos      <= pos_next;
      phase    <= phase_next;
      id_sh    <= id_sh_next;
      size_sh  <= size_sh_next;
      blf      <= blf_next;
      kind_reg <= kind_reg_next;
      status   <= status_next;
      pad      <= pad_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/rwcp_out_reg.sv
// rwcp_out_reg: result register driving the output channel.
// Depends on rwcp_pkg.
`default_nettype none

module rwcp_out_reg
  import rwcp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res,
  output logic         space,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      res_q
);

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

`default_nettype wire

FILE: sv/riff_wave_chunk_parser.sv
// riff_wave_chunk_parser: top level of the RIFF/RF64 WAVE chunk walker.
// Depends on rwcp_pkg, rwcp_in_reg, rwcp_walker, rwcp_out_reg.
//
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// input    | in_valid / in_ready  | file_byte
// output   | out_valid/out_ready  | byte_out byte_role chunk_kind chunk_length
//          |                      | payload_index payload_last form_status
// config   | cfg_valid/cfg_ready  | file_length
//
// One byte per cycle sustained while out_ready stays high; an accepted byte
// passes the input register, then walker logic into the result register.
// Reset clears the walk state, the file length and both valid flags.
// With out_ready low the result register holds, the input register keeps its
// byte (or takes one more if it was empty) and in_ready drops. cfg_ready is always high.
`default_nettype none

module riff_wave_chunk_parser
  import rwcp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  file_byte,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] file_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       byte_out,
  output logic [2:0]       byte_role,
  output logic [3:0]       chunk_kind,
  output logic [31:0]      chunk_length,
  output logic [31:0]      payload_index,
  output logic             payload_last,
  output logic [1:0]       form_status
);

  logic [31:0]  file_len;
  logic         hold_valid;
  logic [7:0]   hold_byte;
  logic         space;
  logic         take;
  result_t      res;
  result_t      res_q;
  walk_status_t wstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_len <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      file_len <= file_length;
    end
  end

  assign take = hold_valid && space;

  rwcp_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .file_byte  (file_byte),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  rwcp_walker u_walk (
    .clk      (clk),
    .rst      (rst),
    .file_len (file_len),
    .byte_in  (hold_byte),
    .take     (take),
    .res      (res),
    .wstat    (wstat)
  );

  rwcp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_q     (res_q)
  );

  assign byte_out      = res_q.byte_val;
  assign byte_role     = res_q.role;
  assign chunk_kind    = res_q.kind;
  assign chunk_length  = res_q.clen;
  assign payload_index = res_q.pidx;
  assign payload_last  = res_q.last;
  assign form_status   = res_q.fstat;

  // a rejected file stays rejected until reset
  a_reject_sticky: assert property (@(posedge clk) disable iff (rst)
    wstat.phase == PH_REJECT |=> wstat.phase == PH_REJECT)
    else $error("walker left reject phase");

  // past the header only an accepted form is walked
  a_walk_status: assert property (@(posedge clk) disable iff (rst)
    (wstat.phase != PH_HEADER && wstat.phase != PH_REJECT) |->
      (wstat.status == STAT_RIFF || wstat.status == STAT_RF64))
    else $error("walking without an accepted header");

  // the last payload byte sits at the end of the clamped length
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && payload_last) |->
      (byte_role == ROLE_PAYLOAD && payload_index == chunk_length - 32'd1))
    else $error("payload_last at wrong offset");

endmodule

`default_nettype wire
